// File: design/lcdseq_pkg.sv
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Shared types, codes and the microcode program of the LCD nibble sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

  localparam int unsigned PcW   = 6;
  localparam int unsigned ByteW = 8;
  localparam int unsigned NibW  = 4;
  localparam int unsigned HoldW = 8;
  localparam int unsigned CfgAW = 1;

  // Command codes
  typedef enum logic [2:0] {
    MODE_DATA   = 3'd0,
    MODE_INSTR  = 3'd1,
    MODE_SETPOS = 3'd2,
    MODE_CURSOR = 3'd3,
    MODE_CLEAR  = 3'd4,
    MODE_INIT   = 3'd5
  } mode_e;

  // Configuration register indexes
  localparam logic [CfgAW-1:0] CFG_PHASE_HOLD = 1'b0;
  localparam logic [CfgAW-1:0] CFG_POWER_WAIT = 1'b1;

  localparam logic [HoldW-1:0] PHASE_HOLD_RST = 8'd5;
  localparam logic [HoldW-1:0] POWER_WAIT_RST = 8'd45;

  // Enable phases of one byte transfer
  typedef enum logic [1:0] {
    PH_HI_EN  = 2'd0,
    PH_HI_DIS = 2'd1,
    PH_LO_EN  = 2'd2,
    PH_LO_DIS = 2'd3
  } phase_e;

  // Program entry points
  localparam logic [PcW-1:0] ENTRY_BYTE = 6'd0;
  localparam logic [PcW-1:0] ENTRY_INIT = 6'd4;
  localparam logic [PcW-1:0] INIT_FIRST = 6'd5;
  localparam logic [PcW-1:0] PROG_LAST  = 6'd32;

  // Fixed instruction bytes
  localparam logic [ByteW-1:0] BYTE_CLEAR    = 8'h01;
  localparam logic [ByteW-1:0] BYTE_SETPOS   = 8'h80;
  localparam logic [ByteW-1:0] BYTE_ROW1     = 8'h40;
  localparam logic [ByteW-1:0] BYTE_CUR_OFF  = 8'b0000_1100;
  localparam logic [ByteW-1:0] BYTE_CUR_ON   = 8'b0000_1110;
  localparam logic [ByteW-1:0] BYTE_CUR_BLNK = 8'h0F;

  // One microcode word
  typedef struct packed {
    logic       wait_evt;  // emit the power-up wait event
    logic       use_init;  // byte comes from the init table
    logic [2:0] init_idx;
    phase_e     phase;
    logic       done;      // last step of the command
  } cw_t;

  // Step issued from the sequencer to the datapath
  typedef struct packed {
    logic fire;
    cw_t  cw;
  } step_t;

  function automatic logic [ByteW-1:0] init_byte(input logic [2:0] idx);
    logic [ByteW-1:0] b;
    unique case (idx)
      3'd0:    b = 8'h33;
      3'd1:    b = 8'h32;
      3'd2:    b = 8'h28;
      3'd3:    b = 8'h08;
      3'd4:    b = 8'h01;
      3'd5:    b = 8'h06;
      3'd6:    b = 8'h0F;
      default: b = 8'h0F;
    endcase
    return b;
  endfunction

  // Program: one byte at ENTRY_BYTE, wait plus seven init bytes at ENTRY_INIT
  function automatic cw_t prog_rom(input logic [PcW-1:0] pc);
    cw_t            cw;
    logic [PcW-1:0] off;
    cw  = '0;
    off = pc - INIT_FIRST;
    if (pc < ENTRY_INIT) begin
      cw.phase = phase_e'(pc[1:0]);
      cw.done  = (pc[1:0] == 2'd3);
    end else if (pc == ENTRY_INIT) begin
      cw.wait_evt = 1'b1;
    end else if (pc <= PROG_LAST) begin
      cw.use_init = 1'b1;
      cw.init_idx = off[4:2];
      cw.phase    = phase_e'(off[1:0]);
      cw.done     = (pc == PROG_LAST);
    end else begin
      cw.done = 1'b1;
    end
    return cw;
  endfunction

endpackage

// File: design/lcdseq_ctrl.sv
// ----------------------------------------------------------------------------
// lcdseq_ctrl
// Step counter over the microcode program, with dispatch on the command mode.
// ----------------------------------------------------------------------------
module lcdseq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,   // command transaction accepted
  input  logic [2:0]          mode_i,
  input  logic [7:0]          value_i,
  input  logic                adv_i,     // event register can take a step
  output logic                busy_o,
  output lcdseq_pkg::step_t   step_o
);

  logic [lcdseq_pkg::PcW-1:0] pc_q, pc_d;
  logic                       run_q, run_d;
  logic                       go;
  logic [lcdseq_pkg::PcW-1:0] entry;
  lcdseq_pkg::cw_t            cw;

  // Dispatch: pick the entry point, drop commands that emit nothing
  always_comb begin
    go    = 1'b0;
    entry = lcdseq_pkg::ENTRY_BYTE;
    unique case (mode_i)
      lcdseq_pkg::MODE_DATA,
      lcdseq_pkg::MODE_INSTR,
      lcdseq_pkg::MODE_SETPOS,
      lcdseq_pkg::MODE_CLEAR:  go = 1'b1;
      lcdseq_pkg::MODE_CURSOR: go = (value_i <= 8'd2);
      lcdseq_pkg::MODE_INIT: begin
        go    = 1'b1;
        entry = lcdseq_pkg::ENTRY_INIT;
      end
      default:                 go = 1'b0;
    endcase
  end

  assign cw = lcdseq_pkg::prog_rom(pc_q);

  // Advance the step counter, stop on the done step
  always_comb begin
    pc_d  = pc_q;
    run_d = run_q;
    priority if (start_i && go) begin
      pc_d  = entry;
      run_d = 1'b1;
    end else if (run_q && adv_i) begin
      pc_d  = pc_q + 1'b1;
      run_d = !cw.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= '0;
      run_q <= 1'b0;
    end else begin
      pc_q  <= pc_d;
      run_q <= run_d;
    end
  end

  assign busy_o      = run_q;
  assign step_o.fire = run_q && adv_i;
  assign step_o.cw   = cw;

endmodule

// File: design/lcdseq_dp.sv
// ----------------------------------------------------------------------------
// lcdseq_dp
// Command byte, hold registers, driven pin state and the pin event register.
// ----------------------------------------------------------------------------
module lcdseq_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_addr_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              load_i,     // command transaction accepted
  input  logic [2:0]        mode_i,
  input  logic [7:0]        value_i,
  input  logic [7:0]        col_i,
  input  logic [7:0]        row_i,
  input  lcdseq_pkg::step_t step_i,
  input  logic              ev_ready_i,
  output logic              adv_o,
  output logic              ev_valid_o,
  output logic              ev_rs_o,
  output logic              ev_en_o,
  output logic [3:0]        ev_nib_o,
  output logic [7:0]        ev_hold_o,
  output logic              ev_last_o
);

  logic [7:0] phase_hold_q, power_wait_q;
  logic [7:0] byte_q, byte_d;
  logic       rs_q, rs_d;
  logic [3:0] drv_nib_q;
  logic       drv_rs_q;
  logic       ev_valid_q;
  logic       ev_rs_q, ev_en_q, ev_last_q;
  logic [3:0] ev_nib_q;
  logic [7:0] ev_hold_q;
  logic [4:0] col_sum;
  logic [3:0] col_mod;
  logic [7:0] pos_byte;
  logic [7:0] cur_byte;
  logic [7:0] src_byte;
  logic       src_rs;
  logic [3:0] src_nib;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_hold_q <= lcdseq_pkg::PHASE_HOLD_RST;
      power_wait_q <= lcdseq_pkg::POWER_WAIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        lcdseq_pkg::CFG_PHASE_HOLD: phase_hold_q <= cfg_wdata_i;
        lcdseq_pkg::CFG_POWER_WAIT: power_wait_q <= cfg_wdata_i;
        default:                    phase_hold_q <= phase_hold_q;
      endcase
    end
  end

  // Column mod 15: 16 is 1 mod 15, so fold the nibbles and correct once
  always_comb begin
    col_sum = {1'b0, col_i[7:4]} + {1'b0, col_i[3:0]};
    priority if (col_sum >= 5'd30) col_mod = 4'(col_sum - 5'd30);
    else if (col_sum >= 5'd15)     col_mod = 4'(col_sum - 5'd15);
    else                           col_mod = col_sum[3:0];
  end

  assign pos_byte = lcdseq_pkg::BYTE_SETPOS
                  | (row_i[0] ? lcdseq_pkg::BYTE_ROW1 : 8'h00)
                  | {4'h0, ((col_i > 8'd15) ? col_mod : col_i[3:0])};

  always_comb begin
    unique case (value_i[1:0])
      2'd0:    cur_byte = lcdseq_pkg::BYTE_CUR_OFF;
      2'd1:    cur_byte = lcdseq_pkg::BYTE_CUR_ON;
      default: cur_byte = lcdseq_pkg::BYTE_CUR_BLNK;
    endcase
  end

  // Latch the command byte and its register select
  always_comb begin
    byte_d = byte_q;
    rs_d   = rs_q;
    if (load_i) begin
      rs_d = 1'b0;
      unique case (mode_i)
        lcdseq_pkg::MODE_DATA: begin
          byte_d = value_i;
          rs_d   = 1'b1;
        end
        lcdseq_pkg::MODE_INSTR:  byte_d = value_i;
        lcdseq_pkg::MODE_SETPOS: byte_d = pos_byte;
        lcdseq_pkg::MODE_CURSOR: byte_d = cur_byte;
        lcdseq_pkg::MODE_CLEAR:  byte_d = lcdseq_pkg::BYTE_CLEAR;
        default:                 byte_d = byte_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    rs_q   <= rs_d;
  end

  // Form the pin event of the current step
  assign src_byte = step_i.cw.use_init ? lcdseq_pkg::init_byte(step_i.cw.init_idx) : byte_q;
  assign src_rs   = step_i.cw.use_init ? 1'b0 : rs_q;
  assign src_nib  = (step_i.cw.phase == lcdseq_pkg::PH_HI_EN ||
                     step_i.cw.phase == lcdseq_pkg::PH_HI_DIS) ? src_byte[7:4]
                                                               : src_byte[3:0];

  assign adv_o = !ev_valid_q || ev_ready_i;

  // Driven pins and event valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_nib_q  <= '0;
      drv_rs_q   <= 1'b0;
      ev_valid_q <= 1'b0;
    end else begin
      if (step_i.fire) begin
        ev_valid_q <= 1'b1;
      end else if (ev_ready_i) begin
        ev_valid_q <= 1'b0;
      end
      if (step_i.fire && !step_i.cw.wait_evt &&
          step_i.cw.phase == lcdseq_pkg::PH_LO_DIS) begin
        drv_nib_q <= src_nib;
        drv_rs_q  <= src_rs;
      end
    end
  end

  // Event payload
  always_ff @(posedge clk_i) begin
    if (step_i.fire) begin
      ev_last_q <= step_i.cw.done;
      if (step_i.cw.wait_evt) begin
        ev_rs_q   <= drv_rs_q;
        ev_en_q   <= 1'b0;
        ev_nib_q  <= drv_nib_q;
        ev_hold_q <= power_wait_q;
      end else begin
        ev_rs_q   <= src_rs;
        ev_en_q   <= (step_i.cw.phase == lcdseq_pkg::PH_HI_EN ||
                      step_i.cw.phase == lcdseq_pkg::PH_LO_EN);
        ev_nib_q  <= src_nib;
        ev_hold_q <= phase_hold_q;
      end
    end
  end

  assign ev_valid_o = ev_valid_q;
  assign ev_rs_o    = ev_rs_q;
  assign ev_en_o    = ev_en_q;
  assign ev_nib_o   = ev_nib_q;
  assign ev_hold_o  = ev_hold_q;
  assign ev_last_o  = ev_last_q;

endmodule

// File: design/char_lcd_nibble_write_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Turns LCD commands into 4-bit bus pin events (RS, E, data nibble, hold).
// ----------------------------------------------------------------------------
// channel   direction  transaction
// s_axis    in         one command: mode, value, col, row
// m_axis    out        one pin event; tlast on the final event of a command
// cfg       in         register write, no handshake
//
// A command is accepted only while the sequencer is idle. Byte commands give
// four events, one per cycle; init gives 29. The next command can be taken
// once the final event is loaded, as the microcode step counter stops at the
// same edge. Commands that emit nothing leave the sequencer idle.
// m_axis_tready low holds the event register and the step counter. Reset
// clears control and pin state.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // mode[2:0], value[10:3], col[18:11], row[26:19]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // enable[0], bus_nibble[4:1], hold_ms[12:5]
  output logic [0:0]  m_axis_tuser,   // reg_select[0]
  output logic        m_axis_tlast
);

  logic              busy;
  logic              adv;
  logic              accept;
  lcdseq_pkg::step_t step;
  logic              ev_en;
  logic [3:0]        ev_nib;
  logic [7:0]        ev_hold;
  logic              ev_rs;

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Step counter and microcode
  lcdseq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .mode_i  (s_axis_tdata[2:0]),
    .value_i (s_axis_tdata[10:3]),
    .adv_i   (adv),
    .busy_o  (busy),
    .step_o  (step)
  );

  // Datapath and event register
  lcdseq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .load_i      (accept),
    .mode_i      (s_axis_tdata[2:0]),
    .value_i     (s_axis_tdata[10:3]),
    .col_i       (s_axis_tdata[18:11]),
    .row_i       (s_axis_tdata[26:19]),
    .step_i      (step),
    .ev_ready_i  (m_axis_tready),
    .adv_o       (adv),
    .ev_valid_o  (m_axis_tvalid),
    .ev_rs_o     (ev_rs),
    .ev_en_o     (ev_en),
    .ev_nib_o    (ev_nib),
    .ev_hold_o   (ev_hold),
    .ev_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, ev_hold, ev_nib, ev_en};
  assign m_axis_tuser = ev_rs;

endmodule

// File: design/lcdseq_chk.sv
// ----------------------------------------------------------------------------
// lcdseq_chk
// Port-level checks of the LCD nibble sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lcdseq_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // Hold a stalled event
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled pin event changed");

  // The final event of a command always drops the enable strobe
  a_last_en_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tlast)
    else $error("command ended with enable high");

  // An idle sequencer only leaves the final event of a command pending
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && s_axis_tready |-> m_axis_tlast)
    else $error("sequencer idle with command events outstanding");

  // A non-final event taken is followed at once by the next one
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a command");

endmodule

bind char_lcd_nibble_write_sequencer lcdseq_chk u_lcdseq_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// File: tb/tb_char_lcd_nibble_write_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_write_sequencer
// Self-checking bench for the 4-bit character LCD write sequencer. Commands
// go in on the slave stream. A local model of the pin sequence queues the
// expected pin events for every accepted command. Each event on the master
// stream is compared field by field against the oldest queued event. Both
// stream sides idle at random. The two timing registers are swept through
// their extremes between traffic phases.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_write_sequencer;

  // Codes that the package does not name
  localparam logic [2:0] MODE_RSVD_A = 3'd6;
  localparam logic [2:0] MODE_RSVD_B = 3'd7;
  localparam logic [7:0] CUR_OFF     = 8'd0;
  localparam logic [7:0] CUR_ON      = 8'd1;
  localparam logic [7:0] CUR_BLINK   = 8'd2;

  localparam logic [7:0] INIT_SEQ [7] = '{8'h33, 8'h32, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0F};

  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned TAIL_CYCLES   = 40;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned LONG_HOLD     = 200;

  typedef struct packed {
    logic       rs;
    logic       en;
    logic [3:0] nib;
    logic [7:0] hold;
    logic       last;
  } pin_evt_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_addr_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // mode[2:0], value[10:3], col[18:11], row[26:19]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // enable[0], bus_nibble[4:1], hold_ms[12:5]
  logic [0:0]  m_axis_tuser;   // reg_select[0]
  logic        m_axis_tlast;

  // Local model state
  pin_evt_t    pending_pins[$];
  logic [3:0]  pins_nibble;
  logic        pins_rs;
  logic [7:0]  hold_cfg;
  logic [7:0]  wait_cfg;

  // Run control and statistics
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  int unsigned rx_hold_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned cmd_count = 0;
  int unsigned init_count = 0;
  int unsigned pin_count = 0;
  int unsigned timing_sets = 0;

  char_lcd_nibble_write_sequencer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Pin sequence model
  // --------------------------------------------------------------------------

  // Queue the four enable phases of one byte and track the pins left driven
  function automatic void queue_byte(input logic rs, input logic [7:0] b, input logic fin);
    pending_pins.push_back('{rs, 1'b1, b[7:4], hold_cfg, 1'b0});
    pending_pins.push_back('{rs, 1'b0, b[7:4], hold_cfg, 1'b0});
    pending_pins.push_back('{rs, 1'b1, b[3:0], hold_cfg, 1'b0});
    pending_pins.push_back('{rs, 1'b0, b[3:0], hold_cfg, fin});
    pins_rs     = rs;
    pins_nibble = b[3:0];
  endfunction

  function automatic void predict_pins(input logic [2:0] mode, input logic [7:0] value,
                                       input logic [7:0] col, input logic [7:0] row);
    logic [7:0] r;
    logic [7:0] c;
    r = (row > 8'd1) ? row % 8'd2 : row;
    c = (col > 8'd15) ? col % 8'd15 : col;
    case (mode)
      lcdseq_pkg::MODE_DATA:   queue_byte(1'b1, value, 1'b1);
      lcdseq_pkg::MODE_INSTR:  queue_byte(1'b0, value, 1'b1);
      lcdseq_pkg::MODE_SETPOS: begin
        queue_byte(1'b0, lcdseq_pkg::BYTE_SETPOS + (r[0] ? lcdseq_pkg::BYTE_ROW1 : 8'h00) + c,
                   1'b1);
      end
      lcdseq_pkg::MODE_CURSOR: begin
        if (value == CUR_OFF) queue_byte(1'b0, lcdseq_pkg::BYTE_CUR_OFF, 1'b1);
        else if (value == CUR_ON) queue_byte(1'b0, lcdseq_pkg::BYTE_CUR_ON, 1'b1);
        else if (value == CUR_BLINK) queue_byte(1'b0, lcdseq_pkg::BYTE_CUR_BLNK, 1'b1);
      end
      lcdseq_pkg::MODE_CLEAR:  queue_byte(1'b0, lcdseq_pkg::BYTE_CLEAR, 1'b1);
      lcdseq_pkg::MODE_INIT: begin
        // power-up wait repeats whatever pins are currently driven
        pending_pins.push_back('{pins_rs, 1'b0, pins_nibble, wait_cfg, 1'b0});
        for (int i = 0; i < 7; i++) queue_byte(1'b0, INIT_SEQ[i], i == 6);
        init_count++;
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offer one command and predict its pin events once it is taken
  task automatic send_cmd(input logic [2:0] mode, input logic [7:0] value,
                          input logic [7:0] col, input logic [7:0] row);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {5'b0, row, col, value, mode};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_pins(mode, value, col, row);
    cmd_count++;
  endtask

  task automatic send_random_cmd();
    int unsigned pick;
    logic [2:0]  mode;
    logic [7:0]  value;
    logic [7:0]  col;
    logic [7:0]  row;
    pick  = $urandom_range(0, 99);
    value = 8'($urandom_range(0, 255));
    col   = 8'($urandom_range(0, 255));
    row   = 8'($urandom_range(0, 255));
    if (pick < 30) begin
      mode = lcdseq_pkg::MODE_DATA;
    end else if (pick < 48) begin
      mode = lcdseq_pkg::MODE_INSTR;
    end else if (pick < 68) begin
      mode = lcdseq_pkg::MODE_SETPOS;
      // keep half of the positions on the visible grid
      if ($urandom_range(0, 1) != 0) begin
        col = 8'($urandom_range(0, 15));
        row = 8'($urandom_range(0, 1));
      end
    end else if (pick < 82) begin
      mode = lcdseq_pkg::MODE_CURSOR;
      if ($urandom_range(0, 3) != 0) value = 8'($urandom_range(CUR_OFF, CUR_BLINK));
    end else if (pick < 90) begin
      mode = lcdseq_pkg::MODE_CLEAR;
    end else if (pick < 95) begin
      mode = lcdseq_pkg::MODE_INIT;
    end else begin
      mode = ($urandom_range(0, 1) != 0) ? MODE_RSVD_A : MODE_RSVD_B;
    end
    send_cmd(mode, value, col, row);
  endtask

  // Drop valid and hold until every predicted pin event has been seen
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_pins.size() != 0) @(posedge clk_i);
  endtask

  // Also let a command that emits nothing finish before touching registers
  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_timing(input logic [7:0] phase_hold, input logic [7:0] power_wait);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= lcdseq_pkg::CFG_PHASE_HOLD;
    cfg_wdata_i <= phase_hold;
    @(posedge clk_i);
    cfg_addr_i  <= lcdseq_pkg::CFG_POWER_WAIT;
    cfg_wdata_i <= power_wait;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    hold_cfg = phase_hold;
    wait_cfg = power_wait;
    timing_sets++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Init straight out of reset, then init after a data byte left RS high
  task automatic test_reset_state();
    send_cmd(lcdseq_pkg::MODE_INIT, 8'h00, 8'h00, 8'h00);
    send_cmd(lcdseq_pkg::MODE_DATA, 8'hA5, 8'h00, 8'h00);
    send_cmd(lcdseq_pkg::MODE_INIT, 8'hFF, 8'hFF, 8'hFF);
    wait_drained();
  endtask

  task automatic test_directed_cmds();
    send_cmd(lcdseq_pkg::MODE_DATA, 8'h00, 8'hFF, 8'hFF);
    send_cmd(lcdseq_pkg::MODE_DATA, 8'hFF, 8'h00, 8'h00);
    send_cmd(lcdseq_pkg::MODE_INSTR, 8'h00, 8'h00, 8'h00);
    send_cmd(lcdseq_pkg::MODE_INSTR, 8'hFF, 8'hFF, 8'hFF);
    // positions on the grid and wrapped ones
    send_cmd(lcdseq_pkg::MODE_SETPOS, 8'h00, 8'd0, 8'd0);
    send_cmd(lcdseq_pkg::MODE_SETPOS, 8'h00, 8'd15, 8'd1);
    send_cmd(lcdseq_pkg::MODE_SETPOS, 8'h00, 8'd16, 8'd2);
    send_cmd(lcdseq_pkg::MODE_SETPOS, 8'h00, 8'd29, 8'd3);
    send_cmd(lcdseq_pkg::MODE_SETPOS, 8'h00, 8'd30, 8'd0);
    send_cmd(lcdseq_pkg::MODE_SETPOS, 8'hFF, 8'd255, 8'd255);
    // cursor styles, including ones that emit nothing
    send_cmd(lcdseq_pkg::MODE_CURSOR, CUR_OFF, 8'h00, 8'h00);
    send_cmd(lcdseq_pkg::MODE_CURSOR, CUR_ON, 8'h00, 8'h00);
    send_cmd(lcdseq_pkg::MODE_CURSOR, CUR_BLINK, 8'h00, 8'h00);
    send_cmd(lcdseq_pkg::MODE_CURSOR, 8'd3, 8'h00, 8'h00);
    send_cmd(lcdseq_pkg::MODE_CURSOR, 8'd255, 8'hFF, 8'hFF);
    send_cmd(lcdseq_pkg::MODE_CLEAR, 8'h5A, 8'h00, 8'h00);
    // unused modes emit nothing and keep the driven pins
    send_cmd(MODE_RSVD_A, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(MODE_RSVD_B, 8'h00, 8'h00, 8'h00);
    send_cmd(lcdseq_pkg::MODE_INIT, 8'h00, 8'h00, 8'h00);
    wait_drained();
  endtask

  // Sweep both timing registers; each burst ends with a command that emits nothing
  task automatic test_timing_extremes();
    logic [7:0] holds [4];
    logic [7:0] waits [4];
    holds = '{8'd1, 8'd255, 8'd1, 8'd255};
    waits = '{8'd1, 8'd255, 8'd255, 8'd1};
    for (int s = 0; s < 4; s++) begin
      wait_idle();
      apply_timing(holds[s], waits[s]);
      send_cmd(lcdseq_pkg::MODE_DATA, 8'($urandom_range(0, 255)), 8'h00, 8'h00);
      send_cmd(lcdseq_pkg::MODE_INIT, 8'h00, 8'h00, 8'h00);
      send_cmd(lcdseq_pkg::MODE_SETPOS, 8'h00, 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
      send_cmd(lcdseq_pkg::MODE_CURSOR, CUR_ON, 8'h00, 8'h00);
      send_cmd(MODE_RSVD_A, 8'($urandom_range(0, 255)), 8'h00, 8'h00);
    end
    wait_idle();
    apply_timing(lcdseq_pkg::PHASE_HOLD_RST, lcdseq_pkg::POWER_WAIT_RST);
  endtask

  // Sink stops for a long stretch while commands keep coming back to back
  task automatic test_output_stall();
    rx_hold_cycles = LONG_HOLD;
    tx_idle = 1'b0;
    send_cmd(lcdseq_pkg::MODE_INIT, 8'h00, 8'h00, 8'h00);
    repeat (9) send_random_cmd();
    tx_idle = 1'b1;
    wait_drained();
  endtask

  // Source pauses mid-stream until the sequencer is fully drained
  task automatic test_sender_pause();
    repeat (6) send_random_cmd();
    wait_drained();
    repeat (6) send_random_cmd();
    wait_drained();
  endtask

  task automatic test_random_traffic();
    // both sides idle at random
    repeat (40) send_random_cmd();
    wait_idle();
    apply_timing(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
    // no idling anywhere
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (40) send_random_cmd();
    wait_idle();
    apply_timing(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
    // only the sink stalls
    rx_idle = 1'b1;
    repeat (35) send_random_cmd();
    // only the source idles
    tx_idle = 1'b1;
    rx_idle = 1'b0;
    repeat (35) send_random_cmd();
    rx_idle = 1'b1;
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence of the run
  // --------------------------------------------------------------------------
  initial begin : run_sequence
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= lcdseq_pkg::CFG_PHASE_HOLD;
    cfg_wdata_i   <= 8'h00;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 32'h0;
    hold_cfg    = lcdseq_pkg::PHASE_HOLD_RST;
    wait_cfg    = lcdseq_pkg::POWER_WAIT_RST;
    pins_rs     = 1'b0;
    pins_nibble = 4'h0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_state();
    test_directed_cmds();
    test_timing_extremes();
    test_output_stall();
    test_sender_pause();
    test_random_traffic();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d commands (%0d power-up inits), checked %0d pin events", cmd_count,
             init_count, pin_count);
    $display("Timing register sets: %0d, with a long sink stall and a drained source pause",
             timing_sets);
    if (mismatch_count == 0 && pending_pins.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sink side: random stalls per transaction, plus a long hold on request
  // --------------------------------------------------------------------------
  initial begin : pin_sink
    int unsigned gap;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end
      gap = rx_idle ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid && rx_hold_cycles == 0) @(posedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // Pin event checker
  // --------------------------------------------------------------------------
  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : pin_checker
    pin_evt_t got;
    pin_evt_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.rs   = m_axis_tuser[0];
      got.en   = m_axis_tdata[0];
      got.nib  = m_axis_tdata[4:1];
      got.hold = m_axis_tdata[12:5];
      got.last = m_axis_tlast;
      pin_count++;
      if (pending_pins.size() == 0) begin
        $display("%0t ns: unexpected pin event, expected none actual %h", $time, got);
        mismatch_count++;
      end else begin
        want = pending_pins.pop_front();
        compare_field("reg_select", 32'(want.rs), 32'(got.rs));
        compare_field("enable", 32'(want.en), 32'(got.en));
        compare_field("bus_nibble", 32'(want.nib), 32'(got.nib));
        compare_field("hold_ms", 32'(want.hold), 32'(got.hold));
        compare_field("last", 32'(want.last), 32'(got.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any transaction on either stream
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: files.f
design/lcdseq_pkg.sv
design/lcdseq_ctrl.sv
design/lcdseq_dp.sv
design/char_lcd_nibble_write_sequencer.sv
design/lcdseq_chk.sv
tb/tb_char_lcd_nibble_write_sequencer.sv
